// ----- sv/irpdd_pkg.sv -----
package irpdd_pkg;

    localparam int DurationWidth = 16;
    localparam int MaxFrameBits  = 64;
    localparam int CodeWidth     = 64;
    localparam int FrameBitsW    = 7;
    localparam int RepeatW       = 3 * DurationWidth;
    localparam int CfgIndexW     = 3;
    localparam int CfgDataW      = RepeatW;
    localparam int FifoDepth     = 4;
    localparam int FifoAw        = $clog2(FifoDepth);
    localparam int CountW        = FifoAw + 1;
    localparam int ProdW         = DurationWidth + 4;

    localparam logic [FrameBitsW-1:0] FrameBitsReset = FrameBitsW'(32);

    typedef enum logic [5:0] {
        FS_IDLE   = 6'b000001,
        FS_HDR    = 6'b000010,
        FS_START  = 6'b000100,
        FS_EITHER = 6'b001000,
        FS_ONE    = 6'b010000,
        FS_ZERO   = 6'b100000
    } t_frame_state;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_HDR_MARK   = 3'd0,
        CFG_HDR_SPACE  = 3'd1,
        CFG_ONE_MARK   = 3'd2,
        CFG_ONE_SPACE  = 3'd3,
        CFG_ZERO_MARK  = 3'd4,
        CFG_ZERO_SPACE = 3'd5,
        CFG_FRAME_BITS = 3'd6,
        CFG_REPEAT     = 3'd7
    } t_cfg_index;

    typedef enum logic {
        KIND_FRAME  = 1'b0,
        KIND_REPEAT = 1'b1
    } t_result_kind;

    // A length matches when it lies strictly between 0.6 and 1.4 times the
    // expected value; an expected value of zero never matches.
    function automatic logic near(input logic [DurationWidth-1:0] len,
                                  input logic [DurationWidth-1:0] expv);
        logic [ProdW-1:0] len10;
        logic [ProdW-1:0] exp6;
        logic [ProdW-1:0] exp14;
        len10 = (ProdW'(len) << 3) + (ProdW'(len) << 1);
        exp6  = (ProdW'(expv) << 2) + (ProdW'(expv) << 1);
        exp14 = (ProdW'(expv) << 4) - (ProdW'(expv) << 1);
        near  = (expv != '0) && (len10 > exp6) && (len10 < exp14);
    endfunction

endpackage

// ----- sv/ir_pulse_distance_decoder_unit.sv -----
// IR pulse-distance decoder.
// Input channel: i_valid, o_stall, with i_is_mark and i_duration; a word is
// taken at a rising edge with i_valid high and o_stall low. Each word is one
// measured mark or space length in microseconds.
// Output channel: o_valid, i_stall, with o_result_kind, o_code_value and
// o_last; a word leaves at a rising edge with o_valid high and i_stall low.
// A decoded frame gives kind 0 with the received bits, a repeat pattern gives
// kind 1 with a zero code. An input that completes both gives the frame word
// first; o_last marks the final word caused by one input.
// The input word is registered, then decoded combinationally into a four-entry
// result queue; a result is offered once its decode has been written there.
// One input word is taken in every cycle while o_stall is low; the rate is set
// by the single decode stage and by the queue, which accepts a decode only
// while it has room for two results.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data,
// one register per cycle, by the user only while the block is idle (unenforced).
// Synchronous active-low reset returns both recognisers to idle, empties the
// queue and restores the register defaults (frame_bits 32, all others zero).
// While the receiver stalls, the queue holds its words; once it is nearly
// full the decode stage waits and, with a word held, o_stall rises.
module ir_pulse_distance_decoder_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic                                      i_is_mark,
    input  logic [irpdd_pkg::DurationWidth-1:0]       i_duration,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic                                      o_result_kind,
    output logic [irpdd_pkg::CodeWidth-1:0]           o_code_value,
    output logic                                      o_last,
    input  logic                                      i_cfg_wr_en,
    input  logic [irpdd_pkg::CfgIndexW-1:0]           i_cfg_index,
    input  logic [irpdd_pkg::CfgDataW-1:0]            i_cfg_data
);

    localparam int Dw = irpdd_pkg::DurationWidth;
    localparam int Mf = irpdd_pkg::MaxFrameBits;
    localparam int Fw = irpdd_pkg::FrameBitsW;
    localparam int Aw = irpdd_pkg::FifoAw;
    localparam int Cw = irpdd_pkg::CountW;

    // Configuration registers.
    logic [Dw-1:0]                    r_hdr_mark;
    logic [Dw-1:0]                    r_hdr_space;
    logic [Dw-1:0]                    r_one_mark;
    logic [Dw-1:0]                    r_one_space;
    logic [Dw-1:0]                    r_zero_mark;
    logic [Dw-1:0]                    r_zero_space;
    logic [Fw-1:0]                    r_frame_bits;
    logic [irpdd_pkg::RepeatW-1:0]    r_repeat;

    // Input register.
    logic                             r_in_valid;
    logic                             r_in_mark;
    logic [Dw-1:0]                    r_in_dur;

    // Recogniser state.
    irpdd_pkg::t_frame_state          r_frame_state, n_frame_state;
    logic [Mf-1:0]                    r_shift, n_shift;
    logic [Fw-1:0]                    r_bits, n_bits;
    logic                             r_rep_space, n_rep_space;
    logic [1:0]                       r_rep_index, n_rep_index;

    // Result queue.
    logic                             r_q_kind [irpdd_pkg::FifoDepth];
    logic [irpdd_pkg::CodeWidth-1:0]  r_q_code [irpdd_pkg::FifoDepth];
    logic                             r_q_last [irpdd_pkg::FifoDepth];
    logic [Aw-1:0]                    r_wr_ptr;
    logic [Aw-1:0]                    r_rd_ptr;
    logic [Cw-1:0]                    r_count;

    logic                             accept_in;
    logic                             can_process;
    logic                             process;
    logic                             pop;
    logic                             frame_emit;
    logic                             rep_emit;
    logic [1:0]                       push_n;
    logic [Dw-1:0]                    rep_elem;
    logic                             push_bit_en;
    logic                             push_bit_val;
    logic                             m_hdr_mark;
    logic                             m_hdr_space;
    logic                             m_one_mark;
    logic                             m_one_space;
    logic                             m_zero_mark;
    logic                             m_zero_space;
    logic                             m_rep;
    logic [1:0]                       rep_index_inc;

    assign can_process = (r_count <= Cw'(irpdd_pkg::FifoDepth - 2));
    assign process     = r_in_valid && can_process;
    assign o_stall     = r_in_valid && !can_process;
    assign accept_in   = i_valid && !o_stall;
    assign o_valid     = (r_count != '0);
    assign pop         = o_valid && !i_stall;

    assign o_result_kind = r_q_kind[r_rd_ptr];
    assign o_code_value  = r_q_code[r_rd_ptr];
    assign o_last        = r_q_last[r_rd_ptr];

    assign m_hdr_mark   = irpdd_pkg::near(r_in_dur, r_hdr_mark);
    assign m_hdr_space  = irpdd_pkg::near(r_in_dur, r_hdr_space);
    assign m_one_mark   = irpdd_pkg::near(r_in_dur, r_one_mark);
    assign m_one_space  = irpdd_pkg::near(r_in_dur, r_one_space);
    assign m_zero_mark  = irpdd_pkg::near(r_in_dur, r_zero_mark);
    assign m_zero_space = irpdd_pkg::near(r_in_dur, r_zero_space);
    assign m_rep        = irpdd_pkg::near(r_in_dur, rep_elem);

    always_comb begin
        case (r_rep_index)
            2'd0:    rep_elem = r_repeat[Dw-1:0];
            2'd1:    rep_elem = r_repeat[2*Dw-1:Dw];
            2'd2:    rep_elem = r_repeat[3*Dw-1:2*Dw];
            default: rep_elem = '0;
        endcase
    end

    // Frame recogniser.
    always_comb begin
        n_frame_state = irpdd_pkg::FS_IDLE;
        frame_emit    = 1'b0;
        push_bit_en   = 1'b0;
        push_bit_val  = 1'b0;
        n_shift       = r_shift;
        n_bits        = r_bits;
        case (r_frame_state)
            irpdd_pkg::FS_HDR: begin
                if (!r_in_mark && m_hdr_space) begin
                    n_frame_state = irpdd_pkg::FS_START;
                    n_shift       = '0;
                    n_bits        = '0;
                end
            end
            irpdd_pkg::FS_START: begin
                if (r_in_mark && (r_bits == r_frame_bits)) begin
                    frame_emit = 1'b1;
                end else if (r_in_mark) begin
                    if (m_one_mark && m_zero_mark) begin
                        n_frame_state = irpdd_pkg::FS_EITHER;
                    end else if (m_one_mark) begin
                        n_frame_state = irpdd_pkg::FS_ONE;
                    end else if (m_zero_mark) begin
                        n_frame_state = irpdd_pkg::FS_ZERO;
                    end
                end
            end
            irpdd_pkg::FS_EITHER: begin
                if (!r_in_mark && m_one_space) begin
                    push_bit_en  = 1'b1;
                    push_bit_val = 1'b1;
                end else if (!r_in_mark && m_zero_space) begin
                    push_bit_en  = 1'b1;
                end
            end
            irpdd_pkg::FS_ONE: begin
                if (!r_in_mark && m_one_space) begin
                    push_bit_en  = 1'b1;
                    push_bit_val = 1'b1;
                end
            end
            irpdd_pkg::FS_ZERO: begin
                if (!r_in_mark && m_zero_space) begin
                    push_bit_en  = 1'b1;
                end
            end
            default: begin
                if (r_in_mark && m_hdr_mark) begin
                    n_frame_state = irpdd_pkg::FS_HDR;
                end
            end
        endcase
        if (push_bit_en) begin
            n_shift       = {r_shift[Mf-2:0], push_bit_val};
            n_bits        = r_bits + Fw'(1);
            n_frame_state = irpdd_pkg::FS_START;
        end
    end

    // Repeat recogniser.
    always_comb begin
        rep_index_inc = r_rep_index + 2'd1;
        rep_emit      = 1'b0;
        n_rep_space   = 1'b0;
        n_rep_index   = 2'd0;
        if (!r_rep_space) begin
            if (r_in_mark && m_rep) begin
                if (rep_index_inc == 2'd3) begin
                    rep_emit = 1'b1;
                end else begin
                    n_rep_space = 1'b1;
                    n_rep_index = rep_index_inc;
                end
            end
        end else if (!r_in_mark && m_rep) begin
            n_rep_index = rep_index_inc;
        end
    end

    assign push_n = process ? (2'(frame_emit) + 2'(rep_emit)) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= '0;
            r_hdr_space  <= '0;
            r_one_mark   <= '0;
            r_one_space  <= '0;
            r_zero_mark  <= '0;
            r_zero_space <= '0;
            r_frame_bits <= irpdd_pkg::FrameBitsReset;
            r_repeat     <= '0;
        end else if (i_cfg_wr_en) begin
            case (irpdd_pkg::t_cfg_index'(i_cfg_index))
                irpdd_pkg::CFG_HDR_MARK:   r_hdr_mark   <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_HDR_SPACE:  r_hdr_space  <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_ONE_MARK:   r_one_mark   <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_ONE_SPACE:  r_one_space  <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_ZERO_MARK:  r_zero_mark  <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_ZERO_SPACE: r_zero_space <= i_cfg_data[Dw-1:0];
                irpdd_pkg::CFG_FRAME_BITS: r_frame_bits <= i_cfg_data[Fw-1:0];
                irpdd_pkg::CFG_REPEAT:     r_repeat     <= i_cfg_data[irpdd_pkg::RepeatW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_mark <= i_is_mark;
            r_in_dur  <= i_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_state <= irpdd_pkg::FS_IDLE;
            r_shift       <= '0;
            r_bits        <= '0;
            r_rep_space   <= 1'b0;
            r_rep_index   <= 2'd0;
        end else if (process) begin
            r_frame_state <= n_frame_state;
            r_shift       <= n_shift;
            r_bits        <= n_bits;
            r_rep_space   <= n_rep_space;
            r_rep_index   <= n_rep_index;
        end
    end

    // The frame word, when present, always goes first.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q_kind[r_wr_ptr] <= frame_emit ? irpdd_pkg::KIND_FRAME
                                             : irpdd_pkg::KIND_REPEAT;
            r_q_code[r_wr_ptr] <= frame_emit ? irpdd_pkg::CodeWidth'(r_shift) : '0;
            r_q_last[r_wr_ptr] <= !(frame_emit && rep_emit);
        end
        if (push_n == 2'd2) begin
            r_q_kind[r_wr_ptr + Aw'(1)] <= irpdd_pkg::KIND_REPEAT;
            r_q_code[r_wr_ptr + Aw'(1)] <= '0;
            r_q_last[r_wr_ptr + Aw'(1)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Aw'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Aw'(1);
            end
            r_count <= r_count + Cw'(push_n) - Cw'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Cw'(irpdd_pkg::FifoDepth))
        else $error("result queue count exceeds its depth");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0 && !pop) |=>
            r_count == $past(r_count) + Cw'($past(push_n)))
        else $error("result queue count lost a push");

    a_emit_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && frame_emit) |-> r_frame_state == irpdd_pkg::FS_START)
        else $error("frame word emitted outside the bit phase");
`endif

endmodule
